@@ rtl/core/ldrt_pkg.sv @@
// ----------------------------------------------------------------------------
// ldrt_pkg: shared types and constants for the distinct-run tracker
// Widths of positions, byte slots and the request payloads of both channels.
// ----------------------------------------------------------------------------
package ldrt_pkg;

  localparam int unsigned POS_BITS  = 16;
  localparam int unsigned ALPHABET  = 256;
  localparam int unsigned SLOT_BITS = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned LEN_BITS  = 17;

  typedef logic [7:0]           byte_t;
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [POS_BITS-1:0]  pos_t;
  typedef logic [POS_BITS:0]    cnt_t;
  typedef logic [LEN_BITS-1:0]  len_t;

  // Bytes at or above the alphabet size share the top slot.
  function automatic slot_t fold_slot(byte_t b);
    slot_t s;
    if ({1'b0, b} >= 9'(ALPHABET)) begin
      s = slot_t'(ALPHABET - 1);
    end else begin
      s = b[SLOT_BITS-1:0];
    end
    return s;
  endfunction

endpackage

@@ rtl/core/ldrt_if.sv @@
// ----------------------------------------------------------------------------
// ldrt channel interfaces
// Valid/ready channels for byte requests in and length results out.
// ----------------------------------------------------------------------------
interface ldrt_in_if;
  logic             valid;
  logic             ready;
  ldrt_pkg::byte_t  char_byte;
  logic             end_of_string;

  modport source (output valid, output char_byte, output end_of_string, input ready);
  modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

interface ldrt_out_if;
  logic            valid;
  logic            ready;
  ldrt_pkg::len_t  best_length;
  ldrt_pkg::len_t  window_length;
  logic            string_done;
  logic            length_overflow;

  modport source (output valid, output best_length, output window_length,
                  output string_done, output length_overflow, input ready);
  modport sink   (input valid, input best_length, input window_length,
                  input string_done, input length_overflow, output ready);
endinterface

@@ rtl/core/longest_distinct_run_tracker.sv @@
// ----------------------------------------------------------------------------
// longest_distinct_run_tracker: longest run of distinct bytes, streamed
// Pipeline: the table is read at request accept into stage 1, then stage 1 updates and loads the result register.
// Throughput: one byte per cycle while the result register is free or being drained.
// Reset: control, window, position and best length clear; the position
//   table holds garbage until written and is qualified by per-slot valid bits.
// ----------------------------------------------------------------------------
module longest_distinct_run_tracker (
  input  logic            clk_i,
  input  logic            rst_ni,
  ldrt_in_if.sink         in_i,
  ldrt_out_if.source      out_o
);
  import ldrt_pkg::*;

  // Position table: last index at which each byte slot occurred.
  pos_t  last_pos_mem [ALPHABET];
  pos_t  mem_rd_q;

  // Stage 1: request waiting for its table read data.
  logic  s1_valid_q;
  slot_t s1_slot_q;
  logic  s1_eos_q;
  logic  s1_fwd_q;   // previous update wrote this slot while we read it

  // Tracker state
  logic [ALPHABET-1:0] seen_q;
  pos_t  wstart_q;
  cnt_t  pos_q;
  cnt_t  best_q;
  logic  ovf_q;

  // Output register
  logic  out_valid_q;
  len_t  out_best_q;
  len_t  out_win_q;
  logic  out_done_q;
  logic  out_ovf_q;

  logic  in_fire, s1_fire, s1_write, saturated;
  slot_t in_slot;
  pos_t  last_pos, wstart_d;
  cnt_t  win_len, best_d;
  logic  hit;

  // Stage 1 fires when the output register is free or being drained.
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_slot    = fold_slot(in_i.char_byte);

  // Once the position counter reaches 2^POS_BITS the string is no longer tracked.
  assign saturated = pos_q[POS_BITS];
  assign s1_write  = s1_fire && !saturated;

  always_comb begin
    // Forward the position written by the previous byte on a back-to-back repeat.
    last_pos = s1_fwd_q ? (pos_q[POS_BITS-1:0] - pos_t'(1)) : mem_rd_q;
    hit      = seen_q[s1_slot_q] && (last_pos >= wstart_q);
    wstart_d = wstart_q;
    best_d   = best_q;
    if (saturated) begin
      win_len = pos_q - {1'b0, wstart_q};
    end else begin
      if (hit) begin
        wstart_d = last_pos + pos_t'(1);
      end
      win_len = {1'b0, pos_q[POS_BITS-1:0]} - {1'b0, wstart_d} + cnt_t'(1);
      if (win_len > best_q) begin
        best_d = win_len;
      end
    end
  end

  // Table memory: one read port (issued at accept), one write port (stage 1).
  always_ff @(posedge clk_i) begin
    if (s1_write) begin
      last_pos_mem[s1_slot_q] <= pos_q[POS_BITS-1:0];
    end
    if (in_fire) begin
      mem_rd_q <= last_pos_mem[in_slot];
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_slot_q <= in_slot;
      s1_eos_q  <= in_i.end_of_string;
      s1_fwd_q  <= s1_write && (s1_slot_q == in_slot);
    end
  end

  // Control and tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seen_q      <= '0;
      wstart_q    <= '0;
      pos_q       <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (s1_fire) begin
        if (s1_eos_q) begin
          // Last byte: clear everything for the next string.
          seen_q   <= '0;
          wstart_q <= '0;
          pos_q    <= '0;
          best_q   <= '0;
          ovf_q    <= 1'b0;
        end else if (saturated) begin
          ovf_q <= 1'b1;
        end else begin
          seen_q[s1_slot_q] <= 1'b1;
          wstart_q          <= wstart_d;
          pos_q             <= pos_q + cnt_t'(1);
          best_q            <= best_d;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_best_q <= len_t'(best_d);
      out_win_q  <= len_t'(win_len);
      out_done_q <= s1_eos_q;
      out_ovf_q  <= ovf_q || saturated;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.best_length     = out_best_q;
  assign out_o.window_length   = out_win_q;
  assign out_o.string_done     = out_done_q;
  assign out_o.length_overflow = out_ovf_q;

endmodule
